// ----- rtl/core/stok_pkg.sv -----
// Shared types, character codes, token kinds and helper functions for the
// S-expression tokenizer. Has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

    localparam int POS_BITS       = 16;
    localparam int MAX_RESULTS    = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Token kinds.
    localparam logic [3:0] KIND_END        = 4'd0;
    localparam logic [3:0] KIND_NUMBER     = 4'd1;
    localparam logic [3:0] KIND_INVALID    = 4'd2;
    localparam logic [3:0] KIND_SYMBOL     = 4'd3;
    localparam logic [3:0] KIND_STRING     = 4'd4;
    localparam logic [3:0] KIND_DOT        = 4'd5;
    localparam logic [3:0] KIND_LPAREN     = 4'd6;
    localparam logic [3:0] KIND_RPAREN     = 4'd7;
    localparam logic [3:0] KIND_QUOTE      = 4'd8;
    localparam logic [3:0] KIND_QUASIQUOTE = 4'd9;
    localparam logic [3:0] KIND_UNQUOTE    = 4'd10;
    localparam logic [3:0] KIND_SPLICING   = 4'd11;
    localparam logic [3:0] KIND_TRUE       = 4'd12;
    localparam logic [3:0] KIND_FALSE      = 4'd13;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef enum logic [10:0] {
        MODE_IDLE    = 11'b000_0000_0001,
        MODE_COMMENT = 11'b000_0000_0010,
        MODE_MINUS   = 11'b000_0000_0100,
        MODE_DOT     = 11'b000_0000_1000,
        MODE_COMMA   = 11'b000_0001_0000,
        MODE_HASH    = 11'b000_0010_0000,
        MODE_NUMBER  = 11'b000_0100_0000,
        MODE_SYMBOL  = 11'b000_1000_0000,
        MODE_BADSYM  = 11'b001_0000_0000,
        MODE_STRING  = 11'b010_0000_0000,
        MODE_ESCAPE  = 11'b100_0000_0000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0]  lexeme_byte;
        logic        has_byte;
        logic        token_last;
        logic [3:0]  token_kind;
        logic [15:0] first_line;
        logic [15:0] first_column;
    } token_item_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return is_space(b) || (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_DQUOTE)
            || (b == CH_QUOTE) || (b == CH_AT) || (b == CH_NUL);
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    // Kind and position are only carried on the final item of a token.
    function automatic token_item_t make_item(input logic [7:0] b, input logic has,
                                              input logic last, input logic [3:0] kind,
                                              input logic [POS_BITS-1:0] line,
                                              input logic [POS_BITS-1:0] col);
        token_item_t item;
        item.lexeme_byte  = b;
        item.has_byte     = has;
        item.token_last   = last;
        item.token_kind   = last ? kind : 4'd0;
        item.first_line   = last ? 16'(line) : 16'd0;
        item.first_column = last ? 16'(col) : 16'd0;
        return item;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/s_expression_tokenizer_unit.sv -----
// S-expression tokenizer top level: byte decoder, position counters and result queue.
// Depends on stok_pkg for types, character codes and token kinds.
//
// Usage: source text arrives one byte per transfer on the text channel
// (text_valid, text_stall, text_byte, end_of_text); a zero byte acts as end of text.
// Token bytes leave one per transfer on the token channel (token_valid,
// token_stall and the item fields). The last item of each token carries its kind,
// start line and start column; end of text flushes the pending token, sends one
// empty end token and returns the scanner to its reset state.
// The results of a byte are registered into the result queue at its transfer.
// Throughput: one byte per cycle while token_stall is low and each byte yields at
// most one result item. A byte may yield up to three items (a token end followed
// by a bracket, an unknown string escape, end of text); the four-entry result queue
// drains one item per cycle while token_stall is low, so such bytes raise text_stall.
// text_stall is raised while the queue holds more than one item.
// When the receiver stalls, the queue head holds steady and fills; input then stalls.
// Reset clears the queue and the scanner state; line is 1 and column is 0.
`timescale 1ns / 1ps
`default_nettype none

module s_expression_tokenizer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        text_valid,
    output logic             text_stall,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    output logic             token_valid,
    input  wire logic        token_stall,
    output logic [7:0]       lexeme_byte,
    output logic             has_byte,
    output logic             token_last,
    output logic [3:0]       token_kind,
    output logic [15:0]      first_line,
    output logic [15:0]      first_column
);

    stok_pkg::scan_mode_t mode_reg, mode_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic held_valid_reg, held_valid_next;
    logic dot_seen_reg, dot_seen_next;
    logic digit_seen_reg, digit_seen_next;
    logic number_bad_reg, number_bad_next;
    logic [stok_pkg::POS_BITS-1:0] line_count_reg, line_count_next;
    logic [stok_pkg::POS_BITS-1:0] column_count_reg, column_count_next;
    logic [stok_pkg::POS_BITS-1:0] token_line_reg, token_line_next;
    logic [stok_pkg::POS_BITS-1:0] token_column_reg, token_column_next;

    stok_pkg::token_item_t res [stok_pkg::MAX_RESULTS];
    logic [1:0] push_n;
    logic accept;
    logic pop;
    logic flush;

    stok_pkg::token_item_t fifo_reg [stok_pkg::QUEUE_DEPTH];
    logic [stok_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [stok_pkg::QUEUE_PTR_BITS:0] count_reg, count_next;
    stok_pkg::token_item_t head;

    assign text_stall  = count_reg > 3'(stok_pkg::QUEUE_DEPTH - stok_pkg::MAX_RESULTS);
    assign accept      = text_valid && !text_stall;
    assign token_valid = count_reg != '0;
    assign pop         = token_valid && !token_stall;
    assign flush       = end_of_text || (text_byte == stok_pkg::CH_NUL);

    always_comb
    begin
        logic [1:0] idx;
        logic again;
        logic [7:0] b;
        logic [7:0] esc;
        logic [stok_pkg::POS_BITS-1:0] tl;
        logic [stok_pkg::POS_BITS-1:0] tc;
        logic [3:0] num_kind;

        mode_next         = mode_reg;
        held_byte_next    = held_byte_reg;
        held_valid_next   = held_valid_reg;
        dot_seen_next     = dot_seen_reg;
        digit_seen_next   = digit_seen_reg;
        number_bad_next   = number_bad_reg;
        line_count_next   = line_count_reg;
        column_count_next = column_count_reg;
        token_line_next   = token_line_reg;
        token_column_next = token_column_reg;
        for (int i = 0; i < stok_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end
        idx      = 2'd0;
        again    = 1'b0;
        esc      = 8'd0;
        b        = text_byte;
        tl       = token_line_reg;
        tc       = token_column_reg;
        num_kind = (number_bad_reg || !digit_seen_reg) ? stok_pkg::KIND_INVALID
                                                       : stok_pkg::KIND_NUMBER;

        if (flush)
        begin
            unique case (mode_reg) inside
                stok_pkg::MODE_MINUS, stok_pkg::MODE_SYMBOL:
                begin
                    res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                   stok_pkg::KIND_SYMBOL, tl, tc);
                    idx = idx + 2'd1;
                end
                stok_pkg::MODE_DOT:
                begin
                    res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                   stok_pkg::KIND_DOT, tl, tc);
                    idx = idx + 2'd1;
                end
                stok_pkg::MODE_COMMA:
                begin
                    res[idx] = stok_pkg::make_item(stok_pkg::CH_COMMA, 1'b1, 1'b1,
                                                   stok_pkg::KIND_UNQUOTE, tl, tc);
                    idx = idx + 2'd1;
                end
                stok_pkg::MODE_HASH:
                begin
                    res[idx] = stok_pkg::make_item(stok_pkg::CH_HASH, 1'b1, 1'b1,
                                                   stok_pkg::KIND_INVALID, tl, tc);
                    idx = idx + 2'd1;
                end
                stok_pkg::MODE_NUMBER:
                begin
                    res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                   num_kind, tl, tc);
                    idx = idx + 2'd1;
                end
                stok_pkg::MODE_BADSYM:
                begin
                    res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                   stok_pkg::KIND_INVALID, tl, tc);
                    idx = idx + 2'd1;
                end
                stok_pkg::MODE_STRING:
                begin
                    // An unterminated string is reported as invalid.
                    res[idx] = stok_pkg::make_item(held_valid_reg ? held_byte_reg : 8'd0,
                                                   held_valid_reg, 1'b1,
                                                   stok_pkg::KIND_INVALID, tl, tc);
                    idx = idx + 2'd1;
                end
                stok_pkg::MODE_ESCAPE:
                begin
                    if (held_valid_reg)
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                    end
                    res[idx] = stok_pkg::make_item(stok_pkg::CH_BSLASH, 1'b1, 1'b1,
                                                   stok_pkg::KIND_INVALID, tl, tc);
                    idx = idx + 2'd1;
                end
                default:
                begin
                end
            endcase
            res[idx] = stok_pkg::make_item(8'd0, 1'b0, 1'b1, stok_pkg::KIND_END,
                                           line_count_reg,
                                           stok_pkg::sat_inc(column_count_reg));
            idx = idx + 2'd1;

            mode_next         = stok_pkg::MODE_IDLE;
            held_byte_next    = 8'd0;
            held_valid_next   = 1'b0;
            dot_seen_next     = 1'b0;
            digit_seen_next   = 1'b0;
            number_bad_next   = 1'b0;
            line_count_next   = stok_pkg::POS_BITS'(1);
            column_count_next = '0;
            token_line_next   = stok_pkg::POS_BITS'(1);
            token_column_next = '0;
        end
        else
        begin
            if (b == stok_pkg::CH_LF)
            begin
                line_count_next   = stok_pkg::sat_inc(line_count_reg);
                column_count_next = '0;
            end
            else
            begin
                column_count_next = stok_pkg::sat_inc(column_count_reg);
            end

            unique case (mode_reg) inside
                stok_pkg::MODE_COMMENT:
                begin
                    if (b == stok_pkg::CH_LF)
                    begin
                        mode_next = stok_pkg::MODE_IDLE;
                    end
                end
                stok_pkg::MODE_MINUS:
                begin
                    if (stok_pkg::is_digit(b) || (b == stok_pkg::CH_DOT))
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                        dot_seen_next   = (b == stok_pkg::CH_DOT);
                        digit_seen_next = (b != stok_pkg::CH_DOT);
                        number_bad_next = 1'b0;
                        mode_next       = stok_pkg::MODE_NUMBER;
                    end
                    else if (stok_pkg::is_delim(b))
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                       stok_pkg::KIND_SYMBOL, tl, tc);
                        idx = idx + 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = stok_pkg::MODE_IDLE;
                        again           = 1'b1;
                    end
                    else
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                        mode_next       = stok_pkg::MODE_SYMBOL;
                    end
                end
                stok_pkg::MODE_DOT:
                begin
                    if (stok_pkg::is_digit(b))
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                        dot_seen_next   = 1'b1;
                        digit_seen_next = 1'b1;
                        number_bad_next = 1'b0;
                        mode_next       = stok_pkg::MODE_NUMBER;
                    end
                    else
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                       stok_pkg::KIND_DOT, tl, tc);
                        idx = idx + 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = stok_pkg::MODE_IDLE;
                        again           = 1'b1;
                    end
                end
                stok_pkg::MODE_COMMA:
                begin
                    held_valid_next = 1'b0;
                    mode_next       = stok_pkg::MODE_IDLE;
                    if (b == stok_pkg::CH_AT)
                    begin
                        res[idx] = stok_pkg::make_item(stok_pkg::CH_COMMA, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        res[idx] = stok_pkg::make_item(stok_pkg::CH_AT, 1'b1, 1'b1,
                                                       stok_pkg::KIND_SPLICING, tl, tc);
                        idx = idx + 2'd1;
                    end
                    else
                    begin
                        res[idx] = stok_pkg::make_item(stok_pkg::CH_COMMA, 1'b1, 1'b1,
                                                       stok_pkg::KIND_UNQUOTE, tl, tc);
                        idx = idx + 2'd1;
                        again = 1'b1;
                    end
                end
                stok_pkg::MODE_HASH:
                begin
                    if ((b == stok_pkg::CH_LOW_T) || (b == stok_pkg::CH_LOW_F))
                    begin
                        res[idx] = stok_pkg::make_item(stok_pkg::CH_HASH, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        res[idx] = stok_pkg::make_item(b, 1'b1, 1'b1,
                                                       (b == stok_pkg::CH_LOW_T)
                                                           ? stok_pkg::KIND_TRUE
                                                           : stok_pkg::KIND_FALSE,
                                                       tl, tc);
                        idx = idx + 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = stok_pkg::MODE_IDLE;
                    end
                    else if (stok_pkg::is_delim(b))
                    begin
                        res[idx] = stok_pkg::make_item(stok_pkg::CH_HASH, 1'b1, 1'b1,
                                                       stok_pkg::KIND_INVALID, tl, tc);
                        idx = idx + 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = stok_pkg::MODE_IDLE;
                        again           = 1'b1;
                    end
                    else
                    begin
                        res[idx] = stok_pkg::make_item(stok_pkg::CH_HASH, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                        mode_next       = stok_pkg::MODE_BADSYM;
                    end
                end
                stok_pkg::MODE_NUMBER:
                begin
                    if (stok_pkg::is_digit(b) || (b == stok_pkg::CH_DOT))
                    begin
                        if (b == stok_pkg::CH_DOT)
                        begin
                            if (dot_seen_reg)
                            begin
                                number_bad_next = 1'b1;
                            end
                            else
                            begin
                                dot_seen_next = 1'b1;
                            end
                        end
                        else
                        begin
                            digit_seen_next = 1'b1;
                        end
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                    end
                    else
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                       num_kind, tl, tc);
                        idx = idx + 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = stok_pkg::MODE_IDLE;
                        again           = 1'b1;
                    end
                end
                stok_pkg::MODE_SYMBOL, stok_pkg::MODE_BADSYM:
                begin
                    if (stok_pkg::is_delim(b))
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b1,
                                                       (mode_reg == stok_pkg::MODE_BADSYM)
                                                           ? stok_pkg::KIND_INVALID
                                                           : stok_pkg::KIND_SYMBOL,
                                                       tl, tc);
                        idx = idx + 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = stok_pkg::MODE_IDLE;
                        again           = 1'b1;
                    end
                    else
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                    end
                end
                stok_pkg::MODE_STRING:
                begin
                    if (b == stok_pkg::CH_DQUOTE)
                    begin
                        // An empty string still gives one item, with no byte.
                        res[idx] = stok_pkg::make_item(held_valid_reg ? held_byte_reg : 8'd0,
                                                       held_valid_reg, 1'b1,
                                                       stok_pkg::KIND_STRING, tl, tc);
                        idx = idx + 2'd1;
                        held_valid_next = 1'b0;
                        mode_next       = stok_pkg::MODE_IDLE;
                    end
                    else if (b == stok_pkg::CH_BSLASH)
                    begin
                        mode_next = stok_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        if (held_valid_reg)
                        begin
                            res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                           stok_pkg::KIND_END, tl, tc);
                            idx = idx + 2'd1;
                        end
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                    end
                end
                stok_pkg::MODE_ESCAPE:
                begin
                    if (held_valid_reg)
                    begin
                        res[idx] = stok_pkg::make_item(held_byte_reg, 1'b1, 1'b0,
                                                       stok_pkg::KIND_END, tl, tc);
                        idx = idx + 2'd1;
                    end
                    unique case (b)
                        stok_pkg::CH_LOW_N:  esc = stok_pkg::CH_LF;
                        stok_pkg::CH_LOW_T:  esc = stok_pkg::CH_TAB;
                        stok_pkg::CH_LOW_R:  esc = stok_pkg::CH_CR;
                        stok_pkg::CH_DQUOTE: esc = stok_pkg::CH_DQUOTE;
                        stok_pkg::CH_BSLASH: esc = stok_pkg::CH_BSLASH;
                        stok_pkg::CH_ZERO:   esc = stok_pkg::CH_NUL;
                        default:
                        begin
                            // Unknown escapes keep the backslash in the text.
                            res[idx] = stok_pkg::make_item(stok_pkg::CH_BSLASH, 1'b1, 1'b0,
                                                           stok_pkg::KIND_END, tl, tc);
                            idx = idx + 2'd1;
                            esc = b;
                        end
                    endcase
                    held_byte_next  = esc;
                    held_valid_next = 1'b1;
                    mode_next       = stok_pkg::MODE_STRING;
                end
                default:
                begin
                    mode_next = stok_pkg::MODE_IDLE;
                    again     = 1'b1;
                end
            endcase

            // The byte that ended a token, or any byte between tokens, is scanned
            // again as the possible start of a new token.
            if (again)
            begin
                if (stok_pkg::is_space(b))
                begin
                end
                else if (b == stok_pkg::CH_SEMI)
                begin
                    mode_next = stok_pkg::MODE_COMMENT;
                end
                else
                begin
                    tl                = line_count_next;
                    tc                = column_count_next;
                    token_line_next   = line_count_next;
                    token_column_next = column_count_next;
                    held_valid_next   = 1'b0;
                    unique case (b)
                        stok_pkg::CH_MINUS:
                        begin
                            held_byte_next  = b;
                            held_valid_next = 1'b1;
                            mode_next       = stok_pkg::MODE_MINUS;
                        end
                        stok_pkg::CH_DOT:
                        begin
                            held_byte_next  = b;
                            held_valid_next = 1'b1;
                            mode_next       = stok_pkg::MODE_DOT;
                        end
                        stok_pkg::CH_COMMA:
                        begin
                            held_byte_next  = b;
                            held_valid_next = 1'b1;
                            mode_next       = stok_pkg::MODE_COMMA;
                        end
                        stok_pkg::CH_HASH:
                        begin
                            held_byte_next  = b;
                            held_valid_next = 1'b1;
                            mode_next       = stok_pkg::MODE_HASH;
                        end
                        stok_pkg::CH_LPAREN:
                        begin
                            res[idx] = stok_pkg::make_item(b, 1'b1, 1'b1,
                                                           stok_pkg::KIND_LPAREN, tl, tc);
                            idx = idx + 2'd1;
                        end
                        stok_pkg::CH_RPAREN:
                        begin
                            res[idx] = stok_pkg::make_item(b, 1'b1, 1'b1,
                                                           stok_pkg::KIND_RPAREN, tl, tc);
                            idx = idx + 2'd1;
                        end
                        stok_pkg::CH_QUOTE:
                        begin
                            res[idx] = stok_pkg::make_item(b, 1'b1, 1'b1,
                                                           stok_pkg::KIND_QUOTE, tl, tc);
                            idx = idx + 2'd1;
                        end
                        stok_pkg::CH_BTICK:
                        begin
                            res[idx] = stok_pkg::make_item(b, 1'b1, 1'b1,
                                                           stok_pkg::KIND_QUASIQUOTE, tl, tc);
                            idx = idx + 2'd1;
                        end
                        stok_pkg::CH_AT:
                        begin
                            res[idx] = stok_pkg::make_item(b, 1'b1, 1'b1,
                                                           stok_pkg::KIND_INVALID, tl, tc);
                            idx = idx + 2'd1;
                        end
                        stok_pkg::CH_DQUOTE:
                        begin
                            mode_next = stok_pkg::MODE_STRING;
                        end
                        default:
                        begin
                            held_byte_next  = b;
                            held_valid_next = 1'b1;
                            if (stok_pkg::is_digit(b))
                            begin
                                dot_seen_next   = 1'b0;
                                digit_seen_next = 1'b1;
                                number_bad_next = 1'b0;
                                mode_next       = stok_pkg::MODE_NUMBER;
                            end
                            else
                            begin
                                mode_next = stok_pkg::MODE_SYMBOL;
                            end
                        end
                    endcase
                end
            end
        end
        push_n = idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= stok_pkg::MODE_IDLE;
            held_byte_reg    <= 8'd0;
            held_valid_reg   <= 1'b0;
            dot_seen_reg     <= 1'b0;
            digit_seen_reg   <= 1'b0;
            number_bad_reg   <= 1'b0;
            line_count_reg   <= stok_pkg::POS_BITS'(1);
            column_count_reg <= '0;
            token_line_reg   <= stok_pkg::POS_BITS'(1);
            token_column_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            held_byte_reg    <= held_byte_next;
            held_valid_reg   <= held_valid_next;
            dot_seen_reg     <= dot_seen_next;
            digit_seen_reg   <= digit_seen_next;
            number_bad_reg   <= number_bad_next;
            line_count_reg   <= line_count_next;
            column_count_reg <= column_count_next;
            token_line_reg   <= token_line_next;
            token_column_reg <= token_column_next;
        end
    end

    // Result queue: up to three items written per transfer, one read per unstalled cycle.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_next + 3'(push_n);
        end
        if (pop)
        begin
            count_next = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + push_n;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < stok_pkg::MAX_RESULTS; i++)
            begin
                if (2'(i) < push_n)
                begin
                    fifo_reg[wr_ptr_reg + 2'(i)] <= res[i];
                end
            end
        end
    end

    assign head         = fifo_reg[rd_ptr_reg];
    assign lexeme_byte  = head.lexeme_byte;
    assign has_byte     = head.has_byte;
    assign token_last   = head.token_last;
    assign token_kind   = head.token_kind;
    assign first_line   = head.first_line;
    assign first_column = head.first_column;

    // The queue never holds more items than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(stok_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

    // End of text always produces at least the end token.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && flush) |-> (push_n != 2'd0))
    else $error("end of text produced no result");

    // After end of text the scanner is back at its reset position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && flush) |=> ((mode_reg == stok_pkg::MODE_IDLE) && !held_valid_reg
                               && (line_count_reg == stok_pkg::POS_BITS'(1))
                               && (column_count_reg == '0)))
    else $error("scanner not reset after end of text");

    // Items inside a token carry no kind or position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && !token_last) |-> ((token_kind == stok_pkg::KIND_END)
                                          && (first_line == 16'd0)
                                          && (first_column == 16'd0) && has_byte))
    else $error("non-final item carries token metadata");

    // Input is held off whenever the queue holds more than one item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > 3'd1) |-> !accept)
    else $error("byte accepted without room for its results");

endmodule

`default_nettype wire

// ----- tb/s_expression_tokenizer_unit_tb.sv -----
// Self-checking testbench for s_expression_tokenizer_unit: a directed table and
// random S-expression documents, checked against typed-in results and a lexer model.
// Depends on stok_pkg for token kinds, character codes and the token item type.
`timescale 1ns / 1ps

module s_expression_tokenizer_unit_tb;

    import stok_pkg::*;

    localparam int LONG_HOLD = 60;

    typedef struct {
        logic [7:0] text;
        logic       eot;
        int         known;   // number of typed-in results, or -1 for the lexer model
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        text_valid = 1'b0;
    logic [7:0]  text_byte = 8'h00;
    logic        end_of_text = 1'b0;
    logic        token_stall = 1'b0;
    wire         text_stall;
    wire         token_valid;
    wire  [7:0]  lexeme_byte;
    wire         has_byte;
    wire         token_last;
    wire  [3:0]  token_kind;
    wire  [15:0] first_line;
    wire  [15:0] first_column;

    int          row_known = -1;
    int          known_next = 0;
    int          mismatch_count = 0;
    int          hold_requests = 0;
    int          burst_left = 0;

    token_item_t awaited_items[$];
    token_item_t step_items[$];
    stim_t       text_plan[$];

    // Lexer state mirrored from the block.
    scan_mode_t          lex_mode;
    logic [7:0]          lex_held;
    logic                lex_held_ok;
    logic                lex_dot;
    logic                lex_digit;
    logic                lex_bad;
    logic [POS_BITS-1:0] cur_line;
    logic [POS_BITS-1:0] cur_col;
    logic [POS_BITS-1:0] tok_line;
    logic [POS_BITS-1:0] tok_col;

    stim_t directed_rows [26] = '{
        '{8'hA5,     1'b1,  1},
        '{CH_LPAREN, 1'b0,  1},
        '{CH_RPAREN, 1'b0,  1},
        '{CH_AT,     1'b0,  1},
        '{CH_BTICK,  1'b0,  1},
        '{CH_QUOTE,  1'b0,  1},
        '{CH_COMMA,  1'b0,  0},
        '{CH_AT,     1'b0,  2},
        '{CH_HASH,   1'b0,  0},
        '{CH_LOW_T,  1'b0,  2},
        '{8'hFF,     1'b0,  0},
        '{CH_DQUOTE, 1'b0,  1},
        '{CH_DQUOTE, 1'b0,  1},
        '{CH_DQUOTE, 1'b0,  0},
        '{CH_BSLASH, 1'b0,  0},
        '{8'h5A,     1'b1,  2},
        '{CH_MINUS,  1'b0, -1},
        '{CH_DOT,    1'b0, -1},
        '{8'h35,     1'b0, -1},
        '{CH_DOT,    1'b0, -1},
        '{CH_NUL,    1'b0, -1},
        '{CH_DQUOTE, 1'b0, -1},
        '{8'h78,     1'b0, -1},
        '{CH_BSLASH, 1'b0, -1},
        '{8'h71,     1'b0, -1},
        '{8'h33,     1'b1, -1}
    };

    // Typed-in results, consumed in order by the rows that name a count.
    token_item_t known_items [14] = '{
        '{8'h00,     1'b0, 1'b1, KIND_END,        16'd1,     16'd1},
        '{CH_LPAREN, 1'b1, 1'b1, KIND_LPAREN,     16'd1,     16'd1},
        '{CH_RPAREN, 1'b1, 1'b1, KIND_RPAREN,     16'd1,     16'd2},
        '{CH_AT,     1'b1, 1'b1, KIND_INVALID,    16'd1,     16'd3},
        '{CH_BTICK,  1'b1, 1'b1, KIND_QUASIQUOTE, 16'd1,     16'd4},
        '{CH_QUOTE,  1'b1, 1'b1, KIND_QUOTE,      16'd1,     16'd5},
        '{CH_COMMA,  1'b1, 1'b0, '0,              16'd0,     16'd0},
        '{CH_AT,     1'b1, 1'b1, KIND_SPLICING,   16'd1,     16'd6},
        '{CH_HASH,   1'b1, 1'b0, '0,              16'd0,     16'd0},
        '{CH_LOW_T,  1'b1, 1'b1, KIND_TRUE,       16'd1,     16'd8},
        '{8'hFF,     1'b1, 1'b1, KIND_SYMBOL,     16'd1,     16'd10},
        '{8'h00,     1'b0, 1'b1, KIND_STRING,     16'd1,     16'd11},
        '{CH_BSLASH, 1'b1, 1'b1, KIND_INVALID,    16'd1,     16'd13},
        '{8'h00,     1'b0, 1'b1, KIND_END,        16'd1,     16'd15}
    };

    s_expression_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .lexeme_byte  (lexeme_byte),
        .has_byte     (has_byte),
        .token_last   (token_last),
        .token_kind   (token_kind),
        .first_line   (first_line),
        .first_column (first_column)
    );

    always #5 clk = ~clk;

    function automatic logic numeral(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic logic breaks_symbol(input logic [7:0] b);
        return blank(b) || b == CH_LPAREN || b == CH_RPAREN || b == CH_DQUOTE
            || b == CH_QUOTE || b == CH_AT || b == CH_NUL;
    endfunction

    function automatic void scanner_reset();
        lex_mode = MODE_IDLE;
        lex_held = 8'h00;
        lex_held_ok = 1'b0;
        lex_dot = 1'b0;
        lex_digit = 1'b0;
        lex_bad = 1'b0;
        cur_line = 1;
        cur_col = 0;
        tok_line = 1;
        tok_col = 0;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic has, input logic last,
                                 input logic [3:0] kind);
        token_item_t t;
        t.lexeme_byte = b;
        t.has_byte = has;
        t.token_last = last;
        t.token_kind = last ? kind : '0;
        t.first_line = last ? tok_line : '0;
        t.first_column = last ? tok_col : '0;
        step_items.push_back(t);
    endfunction

    function automatic void emit_mid(input logic [7:0] b);
        emit(b, 1'b1, 1'b0, '0);
    endfunction

    function automatic void close_token(input logic [7:0] b, input logic [3:0] kind);
        emit(b, 1'b1, 1'b1, kind);
        lex_held_ok = 1'b0;
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void keep(input logic [7:0] b);
        lex_held = b;
        lex_held_ok = 1'b1;
    endfunction

    function automatic void begin_number(input logic dot, input logic digit);
        lex_dot = dot;
        lex_digit = digit;
        lex_bad = 1'b0;
        lex_mode = MODE_NUMBER;
    endfunction

    function automatic logic [3:0] number_kind();
        return (lex_bad || !lex_digit) ? KIND_INVALID : KIND_NUMBER;
    endfunction

    function automatic void start_token(input logic [7:0] b);
        if (blank(b))
            return;
        if (b == CH_SEMI) begin
            lex_mode = MODE_COMMENT;
            return;
        end
        tok_line = cur_line;
        tok_col = cur_col;
        lex_held_ok = 1'b0;
        case (b)
            CH_MINUS:  begin keep(b); lex_mode = MODE_MINUS; end
            CH_DOT:    begin keep(b); lex_mode = MODE_DOT; end
            CH_COMMA:  begin keep(b); lex_mode = MODE_COMMA; end
            CH_HASH:   begin keep(b); lex_mode = MODE_HASH; end
            CH_LPAREN: emit(b, 1'b1, 1'b1, KIND_LPAREN);
            CH_RPAREN: emit(b, 1'b1, 1'b1, KIND_RPAREN);
            CH_QUOTE:  emit(b, 1'b1, 1'b1, KIND_QUOTE);
            CH_BTICK:  emit(b, 1'b1, 1'b1, KIND_QUASIQUOTE);
            CH_AT:     emit(b, 1'b1, 1'b1, KIND_INVALID);
            CH_DQUOTE: lex_mode = MODE_STRING;
            default:
            begin
                keep(b);
                if (numeral(b))
                    begin_number(1'b0, 1'b1);
                else
                    lex_mode = MODE_SYMBOL;
            end
        endcase
    endfunction

    // Works out the token items caused by one accepted text transfer.
    function automatic void lex_text(input logic [7:0] b, input logic eot);
        logic       again;
        logic [7:0] plain;
        step_items.delete();
        again = 1'b0;
        if (eot || b == CH_NUL) begin
            case (lex_mode)
                MODE_MINUS:  emit(lex_held, 1'b1, 1'b1, KIND_SYMBOL);
                MODE_DOT:    emit(lex_held, 1'b1, 1'b1, KIND_DOT);
                MODE_COMMA:  emit(CH_COMMA, 1'b1, 1'b1, KIND_UNQUOTE);
                MODE_HASH:   emit(CH_HASH, 1'b1, 1'b1, KIND_INVALID);
                MODE_NUMBER: emit(lex_held, 1'b1, 1'b1, number_kind());
                MODE_SYMBOL: emit(lex_held, 1'b1, 1'b1, KIND_SYMBOL);
                MODE_BADSYM: emit(lex_held, 1'b1, 1'b1, KIND_INVALID);
                MODE_STRING:
                begin
                    if (lex_held_ok)
                        emit(lex_held, 1'b1, 1'b1, KIND_INVALID);
                    else
                        emit(8'h00, 1'b0, 1'b1, KIND_INVALID);
                end
                MODE_ESCAPE:
                begin
                    // A dangling backslash is passed on alone and spoils the string.
                    if (lex_held_ok)
                        emit_mid(lex_held);
                    emit(CH_BSLASH, 1'b1, 1'b1, KIND_INVALID);
                end
                default: ;
            endcase
            tok_line = cur_line;
            tok_col = (cur_col == POS_MAX) ? cur_col : cur_col + 1'b1;
            emit(8'h00, 1'b0, 1'b1, KIND_END);
            scanner_reset();
            return;
        end

        if (b == CH_LF) begin
            if (cur_line != POS_MAX)
                cur_line = cur_line + 1'b1;
            cur_col = 0;
        end else if (cur_col != POS_MAX) begin
            cur_col = cur_col + 1'b1;
        end

        case (lex_mode)
            MODE_COMMENT:
                if (b == CH_LF)
                    lex_mode = MODE_IDLE;
            MODE_MINUS:
            begin
                if (numeral(b) || b == CH_DOT) begin
                    emit_mid(lex_held);
                    keep(b);
                    begin_number(b == CH_DOT, b != CH_DOT);
                end else if (breaks_symbol(b)) begin
                    close_token(lex_held, KIND_SYMBOL);
                    again = 1'b1;
                end else begin
                    emit_mid(lex_held);
                    keep(b);
                    lex_mode = MODE_SYMBOL;
                end
            end
            MODE_DOT:
            begin
                if (numeral(b)) begin
                    emit_mid(lex_held);
                    keep(b);
                    begin_number(1'b1, 1'b1);
                end else begin
                    close_token(lex_held, KIND_DOT);
                    again = 1'b1;
                end
            end
            MODE_COMMA:
            begin
                lex_held_ok = 1'b0;
                lex_mode = MODE_IDLE;
                if (b == CH_AT) begin
                    emit_mid(CH_COMMA);
                    emit(CH_AT, 1'b1, 1'b1, KIND_SPLICING);
                end else begin
                    emit(CH_COMMA, 1'b1, 1'b1, KIND_UNQUOTE);
                    again = 1'b1;
                end
            end
            MODE_HASH:
            begin
                if (b == CH_LOW_T || b == CH_LOW_F) begin
                    emit_mid(CH_HASH);
                    close_token(b, (b == CH_LOW_T) ? KIND_TRUE : KIND_FALSE);
                end else if (breaks_symbol(b)) begin
                    close_token(CH_HASH, KIND_INVALID);
                    again = 1'b1;
                end else begin
                    emit_mid(CH_HASH);
                    keep(b);
                    lex_mode = MODE_BADSYM;
                end
            end
            MODE_NUMBER:
            begin
                if (numeral(b) || b == CH_DOT) begin
                    if (b == CH_DOT) begin
                        if (lex_dot)
                            lex_bad = 1'b1;
                        else
                            lex_dot = 1'b1;
                    end else begin
                        lex_digit = 1'b1;
                    end
                    emit_mid(lex_held);
                    keep(b);
                end else begin
                    close_token(lex_held, number_kind());
                    again = 1'b1;
                end
            end
            MODE_SYMBOL, MODE_BADSYM:
            begin
                if (breaks_symbol(b)) begin
                    close_token(lex_held, (lex_mode == MODE_BADSYM) ? KIND_INVALID : KIND_SYMBOL);
                    again = 1'b1;
                end else begin
                    emit_mid(lex_held);
                    keep(b);
                end
            end
            MODE_STRING:
            begin
                if (b == CH_DQUOTE) begin
                    if (lex_held_ok)
                        emit(lex_held, 1'b1, 1'b1, KIND_STRING);
                    else
                        emit(8'h00, 1'b0, 1'b1, KIND_STRING);
                    lex_held_ok = 1'b0;
                    lex_mode = MODE_IDLE;
                end else if (b == CH_BSLASH) begin
                    lex_mode = MODE_ESCAPE;
                end else begin
                    if (lex_held_ok)
                        emit_mid(lex_held);
                    keep(b);
                end
            end
            MODE_ESCAPE:
            begin
                if (lex_held_ok)
                    emit_mid(lex_held);
                case (b)
                    CH_LOW_N:  plain = CH_LF;
                    CH_LOW_T:  plain = CH_TAB;
                    CH_LOW_R:  plain = CH_CR;
                    CH_DQUOTE: plain = CH_DQUOTE;
                    CH_BSLASH: plain = CH_BSLASH;
                    CH_ZERO:   plain = CH_NUL;
                    default:
                    begin
                        // Unknown escapes keep their backslash.
                        emit_mid(CH_BSLASH);
                        plain = b;
                    end
                endcase
                keep(plain);
                lex_mode = MODE_STRING;
            end
            default: again = 1'b1;
        endcase
        if (again)
            start_token(b);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: %s is %0h, expected %0h", $time, what, seen, want);
    endtask

    // Scoreboard: predicts on every text transfer and checks every token transfer.
    always @(posedge clk) begin
        token_item_t seen;
        token_item_t want;
        if (rst_n !== 1'b1) begin
            scanner_reset();
        end else begin
            if (text_valid && text_stall === 1'b0) begin
                lex_text(text_byte, end_of_text);
                if (row_known < 0) begin
                    foreach (step_items[i])
                        awaited_items.push_back(step_items[i]);
                end else begin
                    for (int i = 0; i < row_known; i++) begin
                        awaited_items.push_back(known_items[known_next]);
                        known_next++;
                    end
                end
            end
            if (token_valid === 1'b1 && !token_stall) begin
                seen = '{lexeme_byte, has_byte, token_last, token_kind, first_line,
                         first_column};
                if (awaited_items.size() == 0) begin
                    report_mismatch("unexpected token item, lexeme_byte", seen.lexeme_byte, 0);
                end else begin
                    want = awaited_items.pop_front();
                    if (seen.lexeme_byte !== want.lexeme_byte)
                        report_mismatch("lexeme_byte", seen.lexeme_byte, want.lexeme_byte);
                    if (seen.has_byte !== want.has_byte)
                        report_mismatch("has_byte", seen.has_byte, want.has_byte);
                    if (seen.token_last !== want.token_last)
                        report_mismatch("token_last", seen.token_last, want.token_last);
                    if (seen.token_kind !== want.token_kind)
                        report_mismatch("token_kind", seen.token_kind, want.token_kind);
                    if (seen.first_line !== want.first_line)
                        report_mismatch("first_line", seen.first_line, want.first_line);
                    if (seen.first_column !== want.first_column)
                        report_mismatch("first_column", seen.first_column, want.first_column);
                end
            end
        end
    end

    // Receiver: random stall patterns, with a long hold-off whenever one is requested.
    initial begin
        int holds_done;
        int span;
        int style;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (holds_done < hold_requests) begin
                token_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end else begin
                style = $urandom_range(0, 3);
                span = $urandom_range(1, 40);
                repeat (span) begin
                    case (style)
                        0:       token_stall <= 1'b0;
                        1:       token_stall <= ($urandom_range(0, 1) == 1);
                        2:       token_stall <= ($urandom_range(0, 4) != 0);
                        default: token_stall <= ~token_stall;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_text(input logic [7:0] b, input logic eot, input int known);
        text_valid <= 1'b1;
        text_byte <= b;
        end_of_text <= eot;
        row_known <= known;
        @(posedge clk);
        while (text_stall !== 1'b0)
            @(posedge clk);
        if (burst_left == 0) begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 15);
        end else begin
            burst_left--;
        end
    endtask

    task automatic await_drain();
        text_valid <= 1'b0;
        @(posedge clk);
        while (awaited_items.size() != 0)
            @(posedge clk);
    endtask

    function automatic void plan(input logic [7:0] b, input logic eot);
        stim_t s;
        s.text = b;
        s.eot = eot;
        s.known = -1;
        text_plan.push_back(s);
    endfunction

    function automatic void plan_symbol_tail(input int count);
        repeat (count) begin
            case ($urandom_range(0, 9))
                0:       plan(8'($urandom_range(128, 255)), 1'b0);
                1:       plan(8'($urandom_range(1, 8)), 1'b0);
                2:       plan(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                default: plan(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
            endcase
        end
    endfunction

    initial begin
        int         tokens;
        int         tail;
        logic       stop;
        logic [7:0] b;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_text(directed_rows[i].text, directed_rows[i].eot, directed_rows[i].known);

        // Random documents: mostly well-formed tokens with random content and separators.
        for (int round = 0; round < 5; round++) begin
            if (round == 1 || round == 3)
                hold_requests++;
            if (round == 2)
                await_drain();
            while (text_plan.size() < 35) begin
                tokens = $urandom_range(1, 12);
                stop = 1'b0;
                for (int k = 0; k < tokens && !stop; k++) begin
                    case ($urandom_range(0, 15))
                        0:
                        begin
                            if ($urandom_range(0, 2) == 0)
                                plan(CH_MINUS, 1'b0);
                            if ($urandom_range(0, 3) == 0)
                                plan(CH_DOT, 1'b0);
                            tail = $urandom_range(1, 4);
                            repeat (tail)
                                plan(($urandom_range(0, 5) == 0) ? CH_DOT
                                     : CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                        end
                        1:
                        begin
                            if ($urandom_range(0, 3) == 0)
                                plan(CH_MINUS, 1'b0);
                            else
                                plan(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
                            plan_symbol_tail($urandom_range(0, 4));
                        end
                        2:
                        begin
                            plan(CH_DQUOTE, 1'b0);
                            tail = $urandom_range(0, 5);
                            repeat (tail) begin
                                case ($urandom_range(0, 5))
                                    0:
                                    begin
                                        plan(CH_BSLASH, 1'b0);
                                        case ($urandom_range(0, 6))
                                            0:       plan(CH_LOW_N, 1'b0);
                                            1:       plan(CH_LOW_T, 1'b0);
                                            2:       plan(CH_LOW_R, 1'b0);
                                            3:       plan(CH_DQUOTE, 1'b0);
                                            4:       plan(CH_BSLASH, 1'b0);
                                            5:       plan(CH_ZERO, 1'b0);
                                            default: plan(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
                                        endcase
                                    end
                                    1: plan(8'($urandom_range(128, 255)), 1'b0);
                                    default:
                                    begin
                                        b = 8'($urandom_range(32, 126));
                                        if (b == CH_DQUOTE || b == CH_BSLASH)
                                            b = 8'h7A;
                                        plan(b, 1'b0);
                                    end
                                endcase
                            end
                            // Now and then the text ends inside the string.
                            if ($urandom_range(0, 7) == 0) begin
                                if ($urandom_range(0, 1) == 1)
                                    plan(CH_BSLASH, 1'b0);
                                stop = 1'b1;
                            end else begin
                                plan(CH_DQUOTE, 1'b0);
                            end
                        end
                        3:  plan(CH_LPAREN, 1'b0);
                        4:  plan(CH_RPAREN, 1'b0);
                        5:  plan(CH_QUOTE, 1'b0);
                        6:  plan(CH_BTICK, 1'b0);
                        7:  plan(CH_COMMA, 1'b0);
                        8:  begin plan(CH_COMMA, 1'b0); plan(CH_AT, 1'b0); end
                        9:  begin plan(CH_HASH, 1'b0); plan(CH_LOW_T, 1'b0); end
                        10: begin plan(CH_HASH, 1'b0); plan(CH_LOW_F, 1'b0); end
                        11:
                        begin
                            plan(CH_HASH, 1'b0);
                            plan_symbol_tail($urandom_range(0, 3));
                        end
                        12:
                        begin
                            plan(CH_SEMI, 1'b0);
                            repeat ($urandom_range(0, 6))
                                plan(8'($urandom_range(32, 126)), 1'b0);
                            plan(CH_LF, 1'b0);
                        end
                        13: plan(CH_DOT, 1'b0);
                        14: plan(CH_AT, 1'b0);
                        default: plan(8'($urandom_range(1, 255)), 1'b0);
                    endcase
                    if (!stop) begin
                        case ($urandom_range(0, 7))
                            0, 4:    plan(CH_SPACE, 1'b0);
                            1:       plan(CH_TAB, 1'b0);
                            2:       plan(CH_LF, 1'b0);
                            3:       plan(CH_CR, 1'b0);
                            default: ;
                        endcase
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    plan(CH_NUL, 1'b0);
                else
                    plan(8'($urandom), 1'b1);
            end
            foreach (text_plan[i])
                send_text(text_plan[i].text, text_plan[i].eot, text_plan[i].known);
            text_plan.delete();
        end

        await_drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- s_expression_tokenizer_unit.f -----
rtl/core/stok_pkg.sv
rtl/core/s_expression_tokenizer_unit.sv
tb/s_expression_tokenizer_unit_tb.sv
